FILE: rtl/wmf_pkg.sv
// shared constants, types and helpers of the window minimum filter
package wmf_pkg;

  // storage and field sizes
  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 4096;
  localparam int MaxWindow  = 15;
  localparam int PixelBits  = 8;
  localparam int StoreRows  = MaxWindow - 1;
  localparam int WinCap     = ((MaxWindow - 1) / 2) * 2 + 1;
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowBits    = $clog2(MaxHeight);
  localparam int WinIdxBits = $clog2(MaxWindow);

  // register field widths
  localparam int WidthRegBits  = 11;
  localparam int HeightRegBits = 13;
  localparam int WinRegBits    = 4;
  localparam int CfgIdxBits    = 2;
  localparam int CfgDataBits   = 13;

  typedef logic [PixelBits-1:0] pixel_t;

  localparam pixel_t PixMax = {PixelBits{1'b1}};

  // configuration register indexes
  typedef enum logic [CfgIdxBits-1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1,
    RegWinHeight   = 2'd2,
    RegWinWidth    = 2'd3
  } cfg_reg_e;

  // controls from the top level to the line store stage
  typedef struct packed {
    logic load;     // item accepted this cycle
    logic advance;  // whole pipeline moves this cycle
    logic top;      // item lies on the first row of the frame
  } wmf_lm_ctrl_t;

  // controls shared by all horizontal cells
  typedef struct packed {
    logic shift;
    logic clear;
  } wmf_cell_ctrl_t;

  // per-item side information carried down the pipeline
  typedef struct packed {
    logic [ColBits-1:0] col;
    logic [RowBits-1:0] row;
    logic               emit;
    logic               last_in_row;
    logic               last_in_frame;
  } wmf_meta_t;

  function automatic pixel_t pix_min(input pixel_t a, input pixel_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

FILE: rtl/wmf_line_min.sv
// vertical stage: per-column line store of running minima and column minimum
module wmf_line_min (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wmf_pkg::wmf_lm_ctrl_t           ctrl_i,
  input  logic [wmf_pkg::ColBits-1:0]     col_i,
  input  wmf_pkg::pixel_t                 pixel_i,
  input  logic [wmf_pkg::WinIdxBits-1:0]  win_sel_i,
  output wmf_pkg::pixel_t                 col_min_o
);
  import wmf_pkg::*;

  // entry k of a column word: minimum over the last k+1 rows of that column
  typedef logic [StoreRows-1:0][PixelBits-1:0] stack_t;

  stack_t               line_mem_q [MaxWidth];
  stack_t               rd_q;
  stack_t               fwd_data_q;
  stack_t               above;
  stack_t               wr_data;
  logic                 fwd_hit_q;
  logic                 s1_valid_q;
  pixel_t               px_q;
  logic [ColBits-1:0]   col_q;
  logic                 top_q;
  pixel_t               col_min_q;
  pixel_t               vert_min [MaxWindow];

  // a write to the same column in the read cycle is taken from the bypass
  assign above = fwd_hit_q ? fwd_data_q : rd_q;

  // running minima over the rows above, restarted on the first row
  always_comb begin
    vert_min[0] = px_q;
    for (int k = 1; k < MaxWindow; k++) begin
      vert_min[k] = top_q ? px_q : pix_min(px_q, above[k-1]);
    end
    for (int k = 0; k < StoreRows; k++) begin
      wr_data[k] = vert_min[k];
    end
  end

  // line store: write back the updated column word, read for the new item
  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance && s1_valid_q) begin
      line_mem_q[col_q] <= wr_data;
    end
    if (ctrl_i.load) begin
      rd_q <= line_mem_q[col_i];
    end
  end

  // stage valid and bypass hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else if (ctrl_i.advance) begin
      s1_valid_q <= ctrl_i.load;
      fwd_hit_q  <= ctrl_i.load && s1_valid_q && (col_q == col_i);
    end
  end

  // stage payload and column minimum output
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      px_q       <= pixel_i;
      col_q      <= col_i;
      top_q      <= ctrl_i.top;
      fwd_data_q <= wr_data;
    end
    if (ctrl_i.advance && s1_valid_q) begin
      col_min_q <= vert_min[win_sel_i];
    end
  end

  assign col_min_o = col_min_q;

endmodule

FILE: rtl/wmf_min_cell.sv
// horizontal cell: minimum over the last k+1 column minima
module wmf_min_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wmf_pkg::wmf_cell_ctrl_t ctrl_i,
  input  wmf_pkg::pixel_t         col_min_i,
  input  wmf_pkg::pixel_t         left_i,
  output wmf_pkg::pixel_t         value_o
);
  import wmf_pkg::*;

  pixel_t value_q;

  // fold the new column minimum into the neighbor's previous value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= PixMax;
    end else if (ctrl_i.clear) begin
      value_q <= PixMax;
    end else if (ctrl_i.shift) begin
      value_q <= pix_min(col_min_i, left_i);
    end
  end

  assign value_o = value_q;

endmodule

FILE: rtl/window_min_filter_unit.sv
// top level of the rectangular window minimum filter
//
//  channel  | valid / ready                   | payload
//  ---------+---------------------------------+--------------------------------------
//  pixel    | pixel_valid_i / pixel_ready_o   | pixel_i
//  result   | result_valid_o / result_ready_i | min_value_o out_col_o out_row_o
//           |                                 | last_in_row_o last_in_frame_o
//  config   | cfg_valid_i / cfg_ready_o       | cfg_index_i cfg_data_i
//
//  one pixel per cycle unless stalled; results leave via the output register
//  the line store (one word per column, read and written at most once per cycle) and
//  the chain of horizontal cells each advance once per item
//  the pipeline stops only while an emitting item meets a full, stalled output
//  reset and every register write restart the frame; the line store is not cleared
module window_min_filter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pixel_valid_i,
  output logic                                pixel_ready_o,
  input  logic [wmf_pkg::PixelBits-1:0]       pixel_i,
  output logic                                result_valid_o,
  input  logic                                result_ready_i,
  output logic [wmf_pkg::PixelBits-1:0]       min_value_o,
  output logic [wmf_pkg::ColBits-1:0]         out_col_o,
  output logic [wmf_pkg::RowBits-1:0]         out_row_o,
  output logic                                last_in_row_o,
  output logic                                last_in_frame_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wmf_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [wmf_pkg::CfgDataBits-1:0]     cfg_data_i
);
  import wmf_pkg::*;

  logic [WidthRegBits-1:0]  image_width_q;
  logic [HeightRegBits-1:0] image_height_q;
  logic [WinRegBits-1:0]    win_height_q;
  logic [WinRegBits-1:0]    win_width_q;
  logic                     cfg_wr;

  logic [WidthRegBits-1:0]  w_eff;
  logic [HeightRegBits-1:0] h_eff;
  logic [WinRegBits-1:0]    nh;
  logic [WinRegBits-1:0]    nw;
  logic [WinIdxBits-1:0]    nh_m1;
  logic [WinIdxBits-1:0]    nw_m1;

  logic [ColBits-1:0]       col_q, col_d, col_cur;
  logic [RowBits-1:0]       row_q, row_d, row_cur;
  logic [WidthRegBits-1:0]  col_inc;
  logic [HeightRegBits-1:0] row_inc;
  wmf_meta_t                meta_new;

  logic                     accept;
  logic                     advance;
  logic                     s1_valid_q, s2_valid_q, s3_valid_q;
  wmf_meta_t                s1_meta_q, s2_meta_q, s3_meta_q;

  wmf_lm_ctrl_t             lm_ctrl;
  wmf_cell_ctrl_t           cell_ctrl;
  pixel_t                   col_min;
  pixel_t                   cell_val [MaxWindow];

  logic                     out_valid_q, out_valid_d;
  logic                     out_load;
  pixel_t                   min_value_q;
  logic [ColBits-1:0]       out_col_q;
  logic [RowBits-1:0]       out_row_q;
  logic                     last_in_row_q;
  logic                     last_in_frame_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WidthRegBits'(640);
      image_height_q <= HeightRegBits'(480);
      win_height_q   <= WinRegBits'(3);
      win_width_q    <= WinRegBits'(3);
    end else if (cfg_wr) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegImageWidth:  image_width_q  <= cfg_data_i[WidthRegBits-1:0];
        RegImageHeight: image_height_q <= cfg_data_i[HeightRegBits-1:0];
        RegWinHeight:   win_height_q   <= cfg_data_i[WinRegBits-1:0];
        RegWinWidth:    win_width_q    <= cfg_data_i[WinRegBits-1:0];
        default: ;
      endcase
    end
  end

  // effective image size and odd window sizes
  always_comb begin
    if (image_width_q == '0) begin
      w_eff = WidthRegBits'(1);
    end else if (image_width_q > WidthRegBits'(MaxWidth)) begin
      w_eff = WidthRegBits'(MaxWidth);
    end else begin
      w_eff = image_width_q;
    end
    if (image_height_q == '0) begin
      h_eff = HeightRegBits'(1);
    end else if (image_height_q > HeightRegBits'(MaxHeight)) begin
      h_eff = HeightRegBits'(MaxHeight);
    end else begin
      h_eff = image_height_q;
    end
    nh = win_height_q | WinRegBits'(1);
    if (nh > WinRegBits'(WinCap)) begin
      nh = WinRegBits'(WinCap);
    end
    nw = win_width_q | WinRegBits'(1);
    if (nw > WinRegBits'(WinCap)) begin
      nw = WinRegBits'(WinCap);
    end
    nh_m1 = WinIdxBits'(nh - WinRegBits'(1));
    nw_m1 = WinIdxBits'(nw - WinRegBits'(1));
  end

  // raster position of the incoming item, its result tags, next position
  always_comb begin
    col_cur = ({1'b0, col_q} >= w_eff) ? '0 : col_q;
    row_cur = ({1'b0, row_q} >= h_eff) ? '0 : row_q;

    meta_new.emit          = (row_cur >= RowBits'(nh_m1)) && (col_cur >= ColBits'(nw_m1));
    meta_new.col           = col_cur - ColBits'(nw >> 1);
    meta_new.row           = row_cur - RowBits'(nh >> 1);
    meta_new.last_in_row   = ({1'b0, col_cur} == (w_eff - WidthRegBits'(1)));
    meta_new.last_in_frame = meta_new.last_in_row &&
                             ({1'b0, row_cur} == (h_eff - HeightRegBits'(1)));

    col_inc = {1'b0, col_cur} + WidthRegBits'(1);
    row_inc = {1'b0, row_cur} + HeightRegBits'(1);
    col_d   = col_cur;
    row_d   = row_cur;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= h_eff) ? '0 : row_inc[RowBits-1:0];
    end else begin
      col_d = col_inc[ColBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // pipeline moves unless an emitting item meets a full, stalled output
  assign advance       = !(s3_valid_q && s3_meta_q.emit && out_valid_q && !result_ready_i);
  assign pixel_ready_o = advance;
  assign accept        = pixel_valid_i && pixel_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta_new;
    end
    if (advance) begin
      s2_meta_q <= s1_meta_q;
      s3_meta_q <= s2_meta_q;
    end
  end

  // vertical stage
  assign lm_ctrl.load    = accept;
  assign lm_ctrl.advance = advance;
  assign lm_ctrl.top     = (row_cur == '0);

  wmf_line_min u_line_min (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (lm_ctrl),
    .col_i     (col_cur),
    .pixel_i   (pixel_i),
    .win_sel_i (nh_m1),
    .col_min_o (col_min)
  );

  // horizontal chain of cells
  assign cell_ctrl.shift = advance && s2_valid_q;
  assign cell_ctrl.clear = cfg_wr;

  for (genvar k = 0; k < MaxWindow; k++) begin : g_cell
    pixel_t left;
    if (k == 0) begin : g_head
      assign left = PixMax;
    end else begin : g_link
      assign left = cell_val[k-1];
    end
    wmf_min_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .col_min_i (col_min),
      .left_i    (left),
      .value_o   (cell_val[k])
    );
  end

  // output register
  assign out_load = advance && s3_valid_q && s3_meta_q.emit;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      min_value_q     <= cell_val[nw_m1];
      out_col_q       <= s3_meta_q.col;
      out_row_q       <= s3_meta_q.row;
      last_in_row_q   <= s3_meta_q.last_in_row;
      last_in_frame_q <= s3_meta_q.last_in_frame;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign min_value_o     = min_value_q;
  assign out_col_o       = out_col_q;
  assign out_row_o       = out_row_q;
  assign last_in_row_o   = last_in_row_q;
  assign last_in_frame_o = last_in_frame_q;

`ifndef SYNTHESIS
  // an accepted item enters the first stage
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted item did not enter the first stage");

  // raster column stays inside the effective width
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, col_q} < w_eff)
    else $error("column counter beyond image width");

  // a stalled pipeline keeps its last stage
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pixel_ready_o |=> s3_valid_q && $stable(s3_meta_q))
    else $error("last stage changed during a stall");

  // the end of a frame is also the end of a row
  a_frame_end_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_in_frame_o |-> last_in_row_o)
    else $error("frame end flagged off a row end");
`endif

endmodule

FILE: tb/sv/window_min_checker.sv
// channel monitor, window minimum predictor and result comparison for the filter
module window_min_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            pixel_valid_i,
  input  logic                            pixel_ready_i,
  input  logic [wmf_pkg::PixelBits-1:0]   pixel_i,
  input  logic                            result_valid_i,
  input  logic                            result_ready_i,
  input  logic [wmf_pkg::PixelBits-1:0]   min_value_i,
  input  logic [wmf_pkg::ColBits-1:0]     out_col_i,
  input  logic [wmf_pkg::RowBits-1:0]     out_row_i,
  input  logic                            last_in_row_i,
  input  logic                            last_in_frame_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [wmf_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [wmf_pkg::CfgDataBits-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wmf_pkg::*;

  // one window minimum as it leaves the block
  typedef struct packed {
    pixel_t               min_value;
    logic [ColBits-1:0]   col;
    logic [RowBits-1:0]   row;
    logic                 row_end;
    logic                 frame_end;
  } window_min_t;

  window_min_t window_minima_q [$];

  // register copies
  logic [WidthRegBits-1:0]  width_reg;
  logic [HeightRegBits-1:0] height_reg;
  logic [WinRegBits-1:0]    win_rows_reg;
  logic [WinRegBits-1:0]    win_cols_reg;

  // predictor state
  pixel_t      line_mem [StoreRows*MaxWidth];
  pixel_t      col_min_sr [MaxWindow];
  int unsigned col_pos;
  int unsigned row_pos;

  int unsigned fail_cnt;
  int unsigned checked_cnt;

  // zero counts as one, oversize saturates
  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  // even spans round up to odd, capped by the storage
  function automatic int unsigned odd_span(input int unsigned v);
    int unsigned o;
    o = (v / 2) * 2 + 1;
    return (o > WinCap) ? WinCap : o;
  endfunction

  task automatic restart_frame();
    int k;
    col_pos = 0;
    row_pos = 0;
    for (k = 0; k < MaxWindow; k++) col_min_sr[k] = PixMax;
  endtask

  task automatic apply_reg(input cfg_reg_e idx, input logic [CfgDataBits-1:0] data);
    case (idx)
      RegImageWidth:  width_reg    = data[WidthRegBits-1:0];
      RegImageHeight: height_reg   = data[HeightRegBits-1:0];
      RegWinHeight:   win_rows_reg = data[WinRegBits-1:0];
      RegWinWidth:    win_cols_reg = data[WinRegBits-1:0];
      default: ;
    endcase
    restart_frame();
  endtask

  // column minimum over the rows above, then row minimum over the last columns
  task automatic absorb_pixel(input pixel_t px);
    int unsigned w, h, nh, nw, c, r, i, k;
    pixel_t      col_min, win_min, v;
    window_min_t res;
    w  = clamp_dim(width_reg, MaxWidth);
    h  = clamp_dim(height_reg, MaxHeight);
    nh = odd_span(win_rows_reg);
    nw = odd_span(win_cols_reg);
    c  = (col_pos >= w) ? 0 : col_pos;
    r  = (row_pos >= h) ? 0 : row_pos;
    col_min = px;
    for (i = 1; i < nh; i++) begin
      if (r >= i) begin
        v = line_mem[((r - i) % StoreRows) * MaxWidth + c];
        if (v < col_min) col_min = v;
      end
    end
    line_mem[(r % StoreRows) * MaxWidth + c] = px;
    for (k = MaxWindow - 1; k > 0; k--) col_min_sr[k] = col_min_sr[k-1];
    col_min_sr[0] = col_min;
    win_min = col_min_sr[0];
    for (k = 1; k < nw; k++)
      if (col_min_sr[k] < win_min) win_min = col_min_sr[k];
    // only interior centres give a result
    if (r + 1 >= nh && c + 1 >= nw) begin
      res.min_value = win_min;
      res.col       = ColBits'(c - nw / 2);
      res.row       = RowBits'(r - nh / 2);
      res.row_end   = (c == w - 1);
      res.frame_end = (c == w - 1) && (r == h - 1);
      window_minima_q.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic log_failure(input string what, input window_min_t want, input window_min_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%t %s: expected min %0d col %0d row %0d lr %0b lf %0b, got min %0d col %0d row %0d lr %0b lf %0b",
               $time, what, want.min_value, want.col, want.row, want.row_end, want.frame_end,
               got.min_value, got.col, got.row, got.row_end, got.frame_end);
  endtask

  task automatic check_result();
    window_min_t want, got;
    got = {min_value_i, out_col_i, out_row_i, last_in_row_i, last_in_frame_i};
    checked_cnt++;
    if (window_minima_q.size() == 0) begin
      log_failure("unexpected result", '0, got);
    end else begin
      want = window_minima_q.pop_front();
      if (got !== want) log_failure("result mismatch", want, got);
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg    = 640;
      height_reg   = 480;
      win_rows_reg = 3;
      win_cols_reg = 3;
      restart_frame();
      window_minima_q.delete();
      fail_cnt    = 0;
      checked_cnt = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) apply_reg(cfg_reg_e'(cfg_index_i), cfg_data_i);
      if (pixel_valid_i && pixel_ready_i) absorb_pixel(pixel_i);
      if (result_valid_i && result_ready_i) check_result();
    end
    fail_count_o <= fail_cnt;
    pending_o    <= window_minima_q.size();
    checked_o    <= checked_cnt;
  end

endmodule

FILE: tb/sv/window_min_filter_unit_tb.sv
// stimulus and verdict for the window minimum filter regression
module window_min_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmf_pkg::*;

  localparam int unsigned CycleLimit = 4_000_000;

  // directed pixel patterns, first pixel in the top byte
  localparam logic [95:0] ResetProbe = 96'h00ff55aa0180;
  localparam logic [95:0] Tile4x3    = 96'hc8ff5affff07ffff80ffff40;
  localparam logic [95:0] Tiny2x2    = 96'h00ff1122;

  logic clk_i;
  logic rst_n = 1'b0;

  logic                    pixel_valid  = 1'b0;
  pixel_t                  pixel_data   = '0;
  logic                    result_ready = 1'b0;
  logic                    cfg_valid    = 1'b0;
  cfg_reg_e                cfg_index    = RegImageWidth;
  logic [CfgDataBits-1:0]  cfg_data     = '0;

  logic                    pixel_ready_o;
  logic                    result_valid_o;
  pixel_t                  min_value_o;
  logic [ColBits-1:0]      out_col_o;
  logic [RowBits-1:0]      out_row_o;
  logic                    last_in_row_o;
  logic                    last_in_frame_o;
  logic                    cfg_ready_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  int unsigned cycle_cnt  = 0;
  int unsigned ready_hold = 0;
  int unsigned n_pixels   = 0;
  int unsigned n_writes   = 0;
  int unsigned rand_items = 0;
  bit          steady     = 1'b0;

  window_min_filter_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .pixel_valid_i  (pixel_valid),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_i        (pixel_data),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready),
    .min_value_o    (min_value_o),
    .out_col_o      (out_col_o),
    .out_row_o      (out_row_o),
    .last_in_row_o  (last_in_row_o),
    .last_in_frame_o(last_in_frame_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  window_min_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .pixel_valid_i  (pixel_valid),
    .pixel_ready_i  (pixel_ready_o),
    .pixel_i        (pixel_data),
    .result_valid_i (result_valid_o),
    .result_ready_i (result_ready),
    .min_value_i    (min_value_o),
    .out_col_i      (out_col_o),
    .out_row_i      (out_row_o),
    .last_in_row_i  (last_in_row_o),
    .last_in_frame_i(last_in_frame_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("window_min_filter_unit regression: fail");
      $finish;
    end
  end

  // result backpressure: long ready runs, short stalls, a few long ones
  always @(posedge clk_i) begin
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (pick < 45) begin
      result_ready <= 1'b1;
      ready_hold   <= $urandom_range(0, 15);
    end else if (pick < 50) begin
      result_ready <= 1'b1;
      ready_hold   <= $urandom_range(50, 300);
    end else if (pick < 92) begin
      result_ready <= 1'b0;
      ready_hold   <= $urandom_range(0, 2);
    end else begin
      result_ready <= 1'b0;
      ready_hold   <= $urandom_range(10, 40);
    end
  end

  function automatic int unsigned pixel_gap();
    int unsigned pick;
    if (steady) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // mix of flat, bright and dark content so minima vary
  function automatic pixel_t pick_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return pixel_t'($urandom_range(0, 255));
    if (pick < 8) return pixel_t'($urandom_range(180, 255));
    if (pick == 8) return PixMax;
    return pixel_t'($urandom_range(0, 15));
  endfunction

  // unused upper data bits sometimes carry noise
  function automatic logic [CfgDataBits-1:0] pad_junk(input int unsigned v,
                                                      input int unsigned nbits);
    logic [CfgDataBits-1:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? CfgDataBits'($urandom) : '0;
    return (junk << nbits) | CfgDataBits'(v);
  endfunction

  // send one item; the last item of a run always leaves a gap
  task automatic push_pixel(input pixel_t px, input bit last);
    int unsigned gap;
    gap = pixel_gap();
    if (last && gap == 0) gap = 1;
    pixel_valid <= 1'b1;
    pixel_data  <= px;
    do @(posedge clk_i); while (!pixel_ready_o);
    n_pixels++;
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic push_packed(input logic [95:0] bytes, input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) push_pixel(bytes[8*(n-1-k) +: 8], k == n - 1);
  endtask

  task automatic push_random(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) push_pixel(pick_pixel(), k == n - 1);
  endtask

  // all four registers back to back, valid held across writes
  task automatic configure(input logic [CfgDataBits-1:0] w, input logic [CfgDataBits-1:0] h,
                           input logic [CfgDataBits-1:0] rows,
                           input logic [CfgDataBits-1:0] cols);
    logic [CfgDataBits-1:0] vals [4];
    int k;
    vals[0] = w;
    vals[1] = h;
    vals[2] = rows;
    vals[3] = cols;
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_e'(k);
      cfg_data  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      n_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // drain expected minima, then let border items leave the pipeline
  task automatic settle();
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    int unsigned wh_raw, ww_raw, w, h, count;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // reset settings: a few pixels on the top row, no window completes
    push_packed(ResetProbe, 6);
    settle();

    // small 3x3 filter over a 4x3 image
    configure(4, 3, 3, 3);
    push_packed(Tile4x3, 12);
    settle();

    // even window sizes round up and exceed a 2x2 image
    configure(2, 2, 2, 4);
    push_packed(Tiny2x2, 4);
    settle();

    // zero width, zero window, oversize height: one column of 4096 rows
    configure(0, 13'h1fff, 0, 1);
    push_random(40);
    settle();

    // oversize width, zero height: full 1024 wide row, frame wraps
    configure(13'h7ff, 0, 1, 0);
    push_random(1026);
    settle();

    // largest window
    configure(16, 15, 15, 14);
    push_random(240);
    settle();

    // random frames, mostly with windows that fit, sometimes cut short
    while (rand_items < 120) begin
      wh_raw = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(0, 15);
      ww_raw = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(0, 15);
      if ($urandom_range(0, 9) < 9) begin
        w = (ww_raw | 1) + $urandom_range(0, 6);
        h = (wh_raw | 1) + $urandom_range(0, 3);
      end else begin
        w = $urandom_range(1, 20);
        h = $urandom_range(1, 10);
      end
      count = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      steady = ($urandom_range(0, 5) == 0);
      configure(pad_junk(w, WidthRegBits), pad_junk(h, HeightRegBits),
                pad_junk(wh_raw, WinRegBits), pad_junk(ww_raw, WinRegBits));
      push_random(count);
      rand_items += count;
      settle();
    end

    $display("streamed %0d pixels over %0d register writes, random frames and extreme sizes",
             n_pixels, n_writes);
    $display("compared %0d window minima with positions and row/frame end flags", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("window_min_filter_unit regression: pass");
    end else begin
      $display("window_min_filter_unit regression: fail");
    end
    $finish;
  end

endmodule
